// File: rtl/lss_pkg.sv
// shared types and constants for the lifo stack with search
package lss_pkg;

    localparam int unsigned VAL_W = 32;
    localparam int unsigned CNT_W = 5;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_PEEK  = 2'd2,
        OP_COUNT = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        t_opcode                   opcode;
        logic signed [VAL_W-1:0]   operand_value;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0]   top_value;
        logic [CNT_W-1:0]          fill_level;
        logic                      is_empty;
        logic                      is_full;
        logic [CNT_W-1:0]          match_count;
        logic                      is_present;
        t_status                   status;
    } t_out_item;

endpackage

// File: rtl/lss_ram.sv
// generic single write port, single read port ram with registered read
module lss_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/lss_ctrl.sv
// stack sequencer with the shared compare and count unit for match queries
module lss_ctrl #(
    parameter int unsigned STACK_DEPTH = 16,
    parameter int unsigned DATA_WIDTH  = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  lss_pkg::t_in_item              i_in_item,
    output logic                           o_in_ready,
    output logic                           o_res_valid,
    output lss_pkg::t_out_item             o_res_item,
    input  logic                           i_res_take,
    output logic                           o_ram_wr_en,
    output logic [$clog2(STACK_DEPTH)-1:0] o_ram_wr_addr,
    output logic [DATA_WIDTH-1:0]          o_ram_wr_data,
    output logic [$clog2(STACK_DEPTH)-1:0] o_ram_rd_addr,
    input  logic [DATA_WIDTH-1:0]          i_ram_rd_data
);

    import lss_pkg::*;

    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned LW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_POPRD = 5'b00010,
        S_SCAN  = 5'b00100,
        S_LAST  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [LW-1:0]         r_level, n_level;
    logic [LW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_idx, n_idx;
    logic                  r_cmp_vld, n_cmp_vld;
    t_status               r_status, n_status;
    logic [DATA_WIDTH-1:0] r_top, n_top;
    logic [DATA_WIDTH-1:0] r_val, n_val;

    logic [DATA_WIDTH-1:0] in_val;
    logic                  is_empty;
    logic                  is_full;
    logic                  hit;
    logic signed [63:0]    top_sx;

    assign in_val   = DATA_WIDTH'($unsigned(i_in_item.operand_value));
    assign is_empty = (r_level == '0);
    assign is_full  = (r_level == LW'(STACK_DEPTH));
    assign hit      = r_cmp_vld && (i_ram_rd_data == r_val);

    always_comb begin
        n_state       = r_state;
        n_level       = r_level;
        n_count       = r_count;
        n_idx         = r_idx;
        n_cmp_vld     = 1'b0;
        n_status      = r_status;
        n_top         = r_top;
        n_val         = r_val;
        o_ram_wr_en   = 1'b0;
        o_ram_wr_addr = AW'(r_level);
        o_ram_wr_data = in_val;
        o_ram_rd_addr = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_status = ST_OK;
                    n_count  = '0;
                    n_idx    = '0;
                    n_val    = in_val;
                    n_state  = S_DONE;
                    unique case (i_in_item.opcode)
                        OP_PUSH: begin
                            if (is_full) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                o_ram_wr_en = 1'b1;
                                n_level     = r_level + LW'(1);
                                n_top       = in_val;
                            end
                        end
                        OP_POP: begin
                            if (is_empty) begin
                                n_status = ST_UNDERFLOW;
                            end else begin
                                n_level       = r_level - LW'(1);
                                o_ram_rd_addr = AW'(r_level - LW'(2));
                                if (r_level != LW'(1)) begin
                                    n_state = S_POPRD;
                                end
                            end
                        end
                        OP_PEEK: begin
                            if (is_empty) begin
                                n_status = ST_UNDERFLOW;
                            end
                        end
                        OP_COUNT: begin
                            if (!is_empty) begin
                                n_state = S_SCAN;
                            end
                        end
                        default: n_status = ST_OK;
                    endcase
                end
            end
            S_POPRD: begin
                n_top   = i_ram_rd_data;
                n_state = S_DONE;
            end
            S_SCAN: begin
                o_ram_rd_addr = r_idx;
                n_idx         = r_idx + AW'(1);
                n_cmp_vld     = 1'b1;
                if (hit) begin
                    n_count = r_count + LW'(1);
                end
                if (r_idx == AW'(r_level - LW'(1))) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                if (hit) begin
                    n_count = r_count + LW'(1);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_level   <= '0;
            r_count   <= '0;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_status  <= ST_OK;
        end else begin
            r_state   <= n_state;
            r_level   <= n_level;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_cmp_vld <= n_cmp_vld;
            r_status  <= n_status;
        end
        r_top <= n_top;
        r_val <= n_val;
    end

    // sign extend from the data width, then keep the field width
    assign top_sx = 64'(signed'(r_top));

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res_item             = '0;
        o_res_item.top_value   = is_empty ? '0 : top_sx[VAL_W-1:0];
        o_res_item.fill_level  = CNT_W'(r_level);
        o_res_item.is_empty    = is_empty;
        o_res_item.is_full     = is_full;
        o_res_item.match_count = CNT_W'(r_count);
        o_res_item.is_present  = (r_count != '0);
        o_res_item.status      = r_status;
    end

    a_onehot_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LW'(STACK_DEPTH))
        else $error("fill level above depth");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_level)
        else $error("match count above fill level");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && i_in_item.opcode == OP_PUSH && !is_full)
        |=> (r_level == $past(r_level) + LW'(1)))
        else $error("accepted push did not grow the stack");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (LW'(r_idx) < r_level))
        else $error("scan index past fill level");

endmodule

// File: rtl/lifo_stack_with_search.sv
// Last-in first-out stack of STACK_DEPTH entries with a match-count query.
// Push and peek go straight from acceptance to the result; a pop that leaves
// entries behind first passes through a read state, in which one registered
// ram read fetches the new top; and a count query on a non-empty stack scans
// the entries, since one compare and count unit walks the entry ram one
// address per cycle; a count on an empty stack goes straight to the result.
// No item is accepted while one is in progress; a finished result sits in the
// output register, so the next item can be accepted while it waits to be taken.
module lifo_stack_with_search #(
    parameter int unsigned STACK_DEPTH = 16,
    parameter int unsigned DATA_WIDTH  = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lss_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lss_pkg::t_out_item o_out_item
);

    import lss_pkg::*;

    localparam int unsigned AW = $clog2(STACK_DEPTH);

    logic                  in_ready;
    logic                  res_valid;
    t_out_item             res_item;
    logic                  res_take;
    logic                  ram_wr_en;
    logic [AW-1:0]         ram_wr_addr;
    logic [DATA_WIDTH-1:0] ram_wr_data;
    logic [AW-1:0]         ram_rd_addr;
    logic [DATA_WIDTH-1:0] ram_rd_data;

    logic                  r_out_vld, n_out_vld;
    t_out_item             r_out_item;

    lss_ctrl #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_item     (i_in_item),
        .o_in_ready    (in_ready),
        .o_res_valid   (res_valid),
        .o_res_item    (res_item),
        .i_res_take    (res_take),
        .o_ram_wr_en   (ram_wr_en),
        .o_ram_wr_addr (ram_wr_addr),
        .o_ram_wr_data (ram_wr_data),
        .o_ram_rd_addr (ram_rd_addr),
        .i_ram_rd_data (ram_rd_data)
    );

    lss_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // output register
    assign res_take = res_valid && (!r_out_vld || !i_out_stall);

    always_comb begin
        n_out_vld = r_out_vld;
        if (res_take) begin
            n_out_vld = 1'b1;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
        if (res_take) begin
            r_out_item <= res_item;
        end
    end

    assign o_in_stall  = !in_ready;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

endmodule

// File: tb/tb.sv
// self-checking testbench for the lifo stack with search: random and directed stack operations
module tb;
    import lss_pkg::*;

    localparam int unsigned STACK_DEPTH = 16;
    localparam int unsigned DATA_WIDTH  = 32;
    localparam int unsigned RANDOM_OPS  = 1400;
    localparam int unsigned IDLE_LIMIT  = 2000;
    localparam int unsigned DRAIN_WAIT  = 40;
    localparam int unsigned HOLD_AFTER  = 300;
    localparam int unsigned HOLD_CYCLES = 150;

    logic      i_clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    t_in_item  pending_ops[$];
    t_out_item expected_results[$];
    t_out_item want_item;

    logic signed [VAL_W-1:0] stack_entries [STACK_DEPTH];
    int unsigned stack_level = 0;

    int unsigned send_gap     = 0;
    int unsigned stall_left   = 0;
    int unsigned hold_left    = 0;
    bit          hold_done    = 1'b0;
    bit          send_quiet   = 1'b0;
    bit          recv_quiet   = 1'b0;
    int unsigned results_seen = 0;
    int unsigned idle_cycles  = 0;
    int unsigned err_cnt      = 0;

    lifo_stack_with_search #(
        .STACK_DEPTH(STACK_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_out_item apply_stack_op(input t_in_item op_item);
        t_out_item   res;
        int unsigned hits;
        res  = '0;
        hits = 0;
        res.status = ST_OK;
        case (op_item.opcode)
            OP_PUSH: begin
                if (stack_level >= STACK_DEPTH) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    stack_entries[stack_level] = op_item.operand_value;
                    stack_level++;
                end
            end
            OP_POP: begin
                if (stack_level == 0) begin
                    res.status = ST_UNDERFLOW;
                end else begin
                    stack_level--;
                end
            end
            OP_PEEK: begin
                if (stack_level == 0) begin
                    res.status = ST_UNDERFLOW;
                end
            end
            default: begin
                for (int i = 0; i < stack_level; i++) begin
                    if (stack_entries[i] == op_item.operand_value) begin
                        hits++;
                    end
                end
            end
        endcase
        res.top_value   = (stack_level > 0) ? stack_entries[stack_level-1] : '0;
        res.fill_level  = stack_level[CNT_W-1:0];
        res.is_empty    = (stack_level == 0);
        res.is_full     = (stack_level == STACK_DEPTH);
        res.match_count = hits[CNT_W-1:0];
        res.is_present  = (hits != 0);
        return res;
    endfunction

    function automatic int unsigned pick_gap(input bit quiet);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 60) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [VAL_W-1:0] pool_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh0000_0000;
            1:       return 32'shffff_ffff;
            2:       return 32'sh8000_0000;
            3:       return 32'sh7fff_ffff;
            4:       return 32'sh0000_0001;
            5:       return 32'sh5555_5555;
            6:       return 32'shaaaa_aaaa;
            default: return 32'sh0000_002a;
        endcase
    endfunction

    function automatic logic signed [VAL_W-1:0] any_value();
        if ($urandom_range(0, 99) < 60) begin
            return pool_value();
        end
        return $urandom;
    endfunction

    task automatic add_op(input t_opcode op, input logic signed [VAL_W-1:0] val);
        t_in_item op_item;
        op_item.opcode        = op;
        op_item.operand_value = val;
        pending_ops.push_back(op_item);
    endtask

    task automatic check_field(input string name, input logic [VAL_W-1:0] exp_val,
                               input logic [VAL_W-1:0] act_val);
        if (exp_val !== act_val) begin
            err_cnt++;
            if (err_cnt <= 50) begin
                $display("%0t: %s mismatch, expected %0h actual %0h",
                         $time, name, exp_val, act_val);
            end
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                expected_results.push_back(apply_stack_op(in_item));
            end
            if ($urandom_range(0, 49) == 0) begin
                send_quiet <= !send_quiet;
            end
            if (!in_valid || !in_stall) begin
                if (send_gap != 0) begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_ops.size() != 0) begin
                    in_valid <= 1'b1;
                    in_item  <= pending_ops.pop_front();
                    send_gap <= pick_gap(send_quiet);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    err_cnt++;
                    $display("%0t: result with nothing expected, expected none actual %0h",
                             $time, out_item);
                end else begin
                    want_item = expected_results.pop_front();
                    check_field("top_value", VAL_W'(want_item.top_value),
                                VAL_W'(out_item.top_value));
                    check_field("fill_level", VAL_W'(want_item.fill_level),
                                VAL_W'(out_item.fill_level));
                    check_field("is_empty", VAL_W'(want_item.is_empty),
                                VAL_W'(out_item.is_empty));
                    check_field("is_full", VAL_W'(want_item.is_full),
                                VAL_W'(out_item.is_full));
                    check_field("match_count", VAL_W'(want_item.match_count),
                                VAL_W'(out_item.match_count));
                    check_field("is_present", VAL_W'(want_item.is_present),
                                VAL_W'(out_item.is_present));
                    check_field("status", VAL_W'(want_item.status),
                                VAL_W'(out_item.status));
                end
            end
            if ($urandom_range(0, 49) == 0) begin
                recv_quiet <= !recv_quiet;
            end
            if (hold_left != 0) begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end else if (!hold_done && results_seen == HOLD_AFTER) begin
                out_stall <= 1'b1;
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end else if (stall_left != 0) begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end else begin
                out_stall  <= 1'b0;
                stall_left <= pick_gap(recv_quiet);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        int unsigned push_w;
        int unsigned roll;
        int unsigned len;
        logic signed [VAL_W-1:0] fill_val;

        // underflow and empty-count cases
        add_op(OP_POP, 32'sh1234_5678);
        add_op(OP_PEEK, 32'sh0);
        add_op(OP_COUNT, 32'sh0);
        add_op(OP_PUSH, 32'sh8000_0000);
        add_op(OP_PUSH, 32'sh7fff_ffff);
        add_op(OP_PUSH, 32'shffff_ffff);
        add_op(OP_PUSH, 32'sh0000_0000);
        repeat (12) add_op(OP_PUSH, 32'sh5a5a_5a5a);
        // overflow when full
        add_op(OP_PUSH, 32'sh0000_0001);
        add_op(OP_COUNT, 32'sh5a5a_5a5a);
        add_op(OP_COUNT, 32'sh8000_0000);
        add_op(OP_PEEK, 32'shffff_ffff);
        add_op(OP_POP, 32'sh0);
        add_op(OP_COUNT, 32'sh0000_0007);

        while (pending_ops.size() < RANDOM_OPS + 25) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                push_w = $urandom_range(20, 55);
                len    = $urandom_range(10, 30);
                repeat (len) begin
                    roll = $urandom_range(0, 99);
                    if (roll < push_w) begin
                        add_op(OP_PUSH, any_value());
                    end else if (roll < 70) begin
                        add_op(OP_POP, $urandom);
                    end else if (roll < 85) begin
                        add_op(OP_PEEK, $urandom);
                    end else begin
                        add_op(OP_COUNT, any_value());
                    end
                end
            end else if (roll < 85) begin
                // drain then fill with one value so every entry matches
                fill_val = any_value();
                repeat (STACK_DEPTH) add_op(OP_POP, $urandom);
                len = $urandom_range(STACK_DEPTH, STACK_DEPTH + 3);
                repeat (len) add_op(OP_PUSH, fill_val);
                add_op(OP_COUNT, fill_val);
                add_op(OP_PUSH, any_value());
                add_op(OP_PEEK, $urandom);
            end else begin
                len = $urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 4);
                repeat (len) add_op(OP_POP, $urandom);
                add_op(OP_PEEK, $urandom);
                add_op(OP_COUNT, any_value());
            end
        end

        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        while (pending_ops.size() != 0 || in_valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
